// ===== hdl/clxmrng_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clxmrng_pkg
// Shared constants, command types and bit-mixing functions for the combined
// LCG / xorshift / multiply-with-carry random word generator.
// ----------------------------------------------------------------------------
package clxmrng_pkg;

    // Generator constants
    localparam logic [63:0] LCG_MUL  = 64'd2862933555777941757;
    localparam logic [63:0] LCG_ADD  = 64'd7046029254386353087;
    localparam logic [31:0] MWC_MUL  = 32'd4294957665;
    localparam logic [63:0] XS_INIT  = 64'd4101842887655102017;
    localparam logic [63:0] MWC_INIT = 64'd1;

    // LCG multiplier halves for the 32x32 partial products
    localparam logic [31:0] LCG_MUL_LO = LCG_MUL[31:0];
    localparam logic [31:0] LCG_MUL_HI = LCG_MUL[63:32];

    // Shift amounts
    localparam int XS_SHR_A = 17;
    localparam int XS_SHL_B = 31;
    localparam int XS_SHR_C = 8;
    localparam int TM_SHL_A = 21;
    localparam int TM_SHR_B = 35;
    localparam int TM_SHL_C = 4;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL0,
        OP_MUL1,
        OP_MUL2,
        OP_MUL3,
        OP_COMMIT,
        OP_FIX_XS,
        OP_FIX_MWC,
        OP_WORD
    } op_t;

    typedef struct packed {
        op_t  op;
        logic use_cfg_seed;   // LOAD takes the seed register, else seed zero
    } cmd_t;

    // One xorshift advance
    function automatic logic [63:0] xs_advance(input logic [63:0] x);
        logic [63:0] v;
        v = x ^ (x >> XS_SHR_A);
        v = v ^ (v << XS_SHL_B);
        v = v ^ (v >> XS_SHR_C);
        return v;
    endfunction

    // Xorshift tempering of the LCG value
    function automatic logic [63:0] lcg_temper(input logic [63:0] l);
        logic [63:0] t;
        t = l ^ (l << TM_SHL_A);
        t = t ^ (t >> TM_SHR_B);
        t = t ^ (t << TM_SHL_C);
        return t;
    endfunction

endpackage

// ===== hdl/clxmrng_mul32.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clxmrng_mul32
// Shared 32x32 unsigned multiplier with a registered 64-bit product.
// ----------------------------------------------------------------------------
module clxmrng_mul32 (
    input  logic        clk,
    input  logic [31:0] mul_a,
    input  logic [31:0] mul_b,
    output logic [63:0] prod
);

    logic [63:0] prod_reg;
    logic [63:0] prod_next;

    assign prod_next = {32'd0, mul_a} * {32'd0, mul_b};

    // Product register
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

// ===== hdl/clxmrng_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clxmrng_datapath
// Generator states, seed register, partial-product accumulator and output
// word register. Executes one controller operation per cycle.
// ----------------------------------------------------------------------------
module clxmrng_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  clxmrng_pkg::cmd_t   cmd,
    input  logic                cfg_valid,
    input  logic [63:0]         seed_value,
    output logic [63:0]         random_word
);

    logic [63:0] seed_reg;
    logic [63:0] lcg_reg;
    logic [63:0] xs_reg;
    logic [63:0] mwc_reg;
    logic [63:0] acc_reg;
    logic [63:0] word_reg;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] prod;
    logic [63:0] seed_sel;

    // Operand selection for the shared multiplier
    always_comb
    begin
        unique case (cmd.op)
            clxmrng_pkg::OP_MUL0:
            begin
                mul_a = lcg_reg[31:0];
                mul_b = clxmrng_pkg::LCG_MUL_LO;
            end
            clxmrng_pkg::OP_MUL1:
            begin
                mul_a = lcg_reg[31:0];
                mul_b = clxmrng_pkg::LCG_MUL_HI;
            end
            clxmrng_pkg::OP_MUL2:
            begin
                mul_a = lcg_reg[63:32];
                mul_b = clxmrng_pkg::LCG_MUL_LO;
            end
            clxmrng_pkg::OP_MUL3:
            begin
                mul_a = clxmrng_pkg::MWC_MUL;
                mul_b = mwc_reg[31:0];
            end
            default:
            begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    clxmrng_mul32 u_mul (
        .clk   (clk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .prod  (prod)
    );

    assign seed_sel = cmd.use_cfg_seed ? seed_reg : 64'd0;

    // Seed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= 64'd0;
        end
        else if (cfg_valid)
        begin
            seed_reg <= seed_value;
        end
    end

    // Generator states, accumulator and output word
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            clxmrng_pkg::OP_LOAD:
            begin
                xs_reg  <= clxmrng_pkg::XS_INIT;
                mwc_reg <= clxmrng_pkg::MWC_INIT;
                lcg_reg <= seed_sel ^ clxmrng_pkg::XS_INIT;
            end
            clxmrng_pkg::OP_MUL1:
            begin
                acc_reg <= prod;                       // lo x lo
            end
            clxmrng_pkg::OP_MUL2, clxmrng_pkg::OP_MUL3:
            begin
                acc_reg[63:32] <= acc_reg[63:32] + prod[31:0];  // cross terms
            end
            clxmrng_pkg::OP_COMMIT:
            begin
                lcg_reg <= acc_reg + clxmrng_pkg::LCG_ADD;
                xs_reg  <= clxmrng_pkg::xs_advance(xs_reg);
                mwc_reg <= prod + {32'd0, mwc_reg[63:32]};
            end
            clxmrng_pkg::OP_FIX_XS:
            begin
                xs_reg <= lcg_reg;
            end
            clxmrng_pkg::OP_FIX_MWC:
            begin
                mwc_reg <= xs_reg;
            end
            clxmrng_pkg::OP_WORD:
            begin
                word_reg <= (clxmrng_pkg::lcg_temper(lcg_reg) + xs_reg) ^ mwc_reg;
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    assign random_word = word_reg;

endmodule

// ===== hdl/clxmrng_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clxmrng_ctrl
// Sequencer: reset-time seeding, restart warm-up, the multiply steps of each
// draw and the output handshake.
// ----------------------------------------------------------------------------
module clxmrng_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic              restart,
    output logic              req_stall,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output clxmrng_pkg::cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_M0,
        S_M1,
        S_M2,
        S_M3,
        S_COMMIT,
        S_FIX_XS,
        S_FIX_MWC,
        S_WORD
    } state_t;

    // Which draw of a seeding sequence is running
    typedef enum logic [1:0] {
        D_WARM0,
        D_WARM1,
        D_WARM2,
        D_MAIN
    } draw_t;

    state_t state_reg;
    draw_t  draw_reg;
    logic   init_reg;
    logic   rsp_valid_reg;
    logic   slot_free;

    assign slot_free = !rsp_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;

    // Command decode
    always_comb
    begin
        cmd.use_cfg_seed = !init_reg;
        unique case (state_reg)
            S_LOAD:    cmd.op = clxmrng_pkg::OP_LOAD;
            S_M0:      cmd.op = clxmrng_pkg::OP_MUL0;
            S_M1:      cmd.op = clxmrng_pkg::OP_MUL1;
            S_M2:      cmd.op = clxmrng_pkg::OP_MUL2;
            S_M3:      cmd.op = clxmrng_pkg::OP_MUL3;
            S_COMMIT:  cmd.op = clxmrng_pkg::OP_COMMIT;
            S_FIX_XS:  cmd.op = clxmrng_pkg::OP_FIX_XS;
            S_FIX_MWC: cmd.op = clxmrng_pkg::OP_FIX_MWC;
            S_WORD:    cmd.op = slot_free ? clxmrng_pkg::OP_WORD : clxmrng_pkg::OP_NONE;
            default:   cmd.op = clxmrng_pkg::OP_NONE;
        endcase
    end

    // State machine and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            draw_reg      <= D_WARM0;
            init_reg      <= 1'b1;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            // Response valid: set as the word is loaded, cleared once taken
            if (state_reg == S_WORD && slot_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        if (restart)
                        begin
                            state_reg <= S_LOAD;
                            draw_reg  <= D_WARM0;
                        end
                        else
                        begin
                            state_reg <= S_M0;
                            draw_reg  <= D_MAIN;
                        end
                    end
                end
                S_LOAD:   state_reg <= S_M0;
                S_M0:     state_reg <= S_M1;
                S_M1:     state_reg <= S_M2;
                S_M2:     state_reg <= S_M3;
                S_M3:     state_reg <= S_COMMIT;
                S_COMMIT:
                begin
                    unique case (draw_reg)
                        D_WARM0: state_reg <= S_FIX_XS;
                        D_WARM1: state_reg <= S_FIX_MWC;
                        D_WARM2:
                        begin
                            if (init_reg)
                            begin
                                state_reg <= S_IDLE;
                                init_reg  <= 1'b0;
                            end
                            else
                            begin
                                state_reg <= S_M0;
                                draw_reg  <= D_MAIN;
                            end
                        end
                        default: state_reg <= S_WORD;
                    endcase
                end
                S_FIX_XS:
                begin
                    state_reg <= S_M0;
                    draw_reg  <= D_WARM1;
                end
                S_FIX_MWC:
                begin
                    state_reg <= S_M0;
                    draw_reg  <= D_WARM2;
                end
                S_WORD:
                begin
                    if (slot_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:  state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== hdl/combined_lcg_xorshift_mwc_rng.sv =====
`timescale 1ns / 1ps
// A plain draw runs four multiply steps on the shared 32x32 multiplier, then commit
//   and word load; a restart draw first loads the seed and runs three warm-up draws.
//   Requests are taken only in the idle state, after the previous word is loaded. A
//   response held by rsp_stall delays the next word load until it is taken.
// Reset: seed register clears to 0; the block then seeds all states from seed 0
//   with req_stall high (configuration writes still taken).
// ----------------------------------------------------------------------------
// combined_lcg_xorshift_mwc_rng
// Combined 64-bit random word generator: tempered LCG plus xorshift, XORed
// with a multiply-with-carry state. One word per request transaction.
// ----------------------------------------------------------------------------
module combined_lcg_xorshift_mwc_rng (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic        restart,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [63:0] random_word,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [63:0] seed_value
);

    clxmrng_pkg::cmd_t cmd;

    // Seed register always accepts writes
    assign cfg_ready = 1'b1;

    clxmrng_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .restart   (restart),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd)
    );

    clxmrng_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cfg_valid   (cfg_valid),
        .seed_value  (seed_value),
        .random_word (random_word)
    );

endmodule

// ===== tb/combined_lcg_xorshift_mwc_rng_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// combined_lcg_xorshift_mwc_rng_tb
// Self-checking bench for the combined LCG / xorshift / MWC word generator.
// A local model of the three generator states predicts each word. Request and
// response sides idle at random, and the seed register is rewritten between
// phases. The bench covers the stream from reset, restarts from extreme seeds,
// and a long random stream with sparse restarts.
// ----------------------------------------------------------------------------
module combined_lcg_xorshift_mwc_rng_tb;

    // Generator constants for the local model
    localparam logic [63:0] LCG_MULT = 64'd2862933555777941757;
    localparam logic [63:0] LCG_INC  = 64'd7046029254386353087;
    localparam logic [63:0] MWC_MULT = 64'd4294957665;
    localparam logic [63:0] XS_SEED  = 64'd4101842887655102017;

    localparam int MAX_WAIT     = 13;
    localparam int MAX_REPORTED = 10;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 110;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    logic        restart = 1'b0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    logic [63:0] random_word;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [63:0] seed_value = 64'd0;

    // Model state: seed register and the three generator states
    logic [63:0] seed_q;
    logic [63:0] lcg_q;
    logic [63:0] xs_q;
    logic [63:0] mwc_q;

    logic [63:0] expected_words[$];
    int          mismatches = 0;
    int          rsp_hold = 0;
    logic        send_burst = 1'b0;
    logic        rsp_burst = 1'b0;

    combined_lcg_xorshift_mwc_rng u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .restart     (restart),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .random_word (random_word),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .seed_value  (seed_value)
    );

    always #5 clk = ~clk;

    // Advance all three generators and combine them into one word
    function automatic logic [63:0] next_random_word();
        logic [63:0] t;
        lcg_q = lcg_q * LCG_MULT + LCG_INC;
        xs_q  = xs_q ^ (xs_q >> 17);
        xs_q  = xs_q ^ (xs_q << 31);
        xs_q  = xs_q ^ (xs_q >> 8);
        mwc_q = MWC_MULT * {32'd0, mwc_q[31:0]} + {32'd0, mwc_q[63:32]};
        t = lcg_q ^ (lcg_q << 21);
        t = t ^ (t >> 35);
        t = t ^ (t << 4);
        return (t + xs_q) ^ mwc_q;
    endfunction

    // Seeding with three discarded warm-up draws
    function automatic void reseed_states(input logic [63:0] s);
        xs_q  = XS_SEED;
        mwc_q = 64'd1;
        lcg_q = s ^ xs_q;
        void'(next_random_word());
        xs_q = lcg_q;
        void'(next_random_word());
        mwc_q = xs_q;
        void'(next_random_word());
    endfunction

    // Response stall: a random hold after each transaction unless bursting
    always @(negedge clk) begin
        if (rsp_hold > 0) begin
            rsp_stall = 1'b1;
            rsp_hold  = rsp_hold - 1;
        end
        else begin
            rsp_stall = 1'b0;
        end
    end

    // Response checker
    always @(posedge clk) begin
        logic [63:0] want;
        if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
                mismatches = mismatches + 1;
                if (mismatches <= MAX_REPORTED)
                    $display("ERROR: unexpected word %h", random_word);
            end
            else begin
                want = expected_words.pop_front();
                if (random_word !== want) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= MAX_REPORTED)
                        $display("ERROR: random_word expected %h actual %h", want, random_word);
                end
            end
            rsp_hold = rsp_burst ? 0 : $urandom_range(0, MAX_WAIT);
        end
    end

    // One request transaction; starts and returns at a falling edge
    task automatic send_request(input logic do_restart);
        int   gap;
        logic taken;
        gap = send_burst ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap != 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid = 1'b1;
        restart   = do_restart;
        taken     = 1'b0;
        while (!taken) begin
            @(posedge clk);
            if (!req_stall) begin
                taken = 1'b1;
                if (do_restart)
                    reseed_states(seed_q);
                expected_words.push_back(next_random_word());
            end
            @(negedge clk);
        end
    endtask

    // Hold off requests until every expected word has arrived
    task automatic drain_words();
        req_valid = 1'b0;
        while (expected_words.size() != 0)
            @(negedge clk);
    endtask

    // Seed register write; only issued while the block is idle
    task automatic write_seed(input logic [63:0] s);
        logic taken;
        cfg_valid  = 1'b1;
        seed_value = s;
        taken      = 1'b0;
        while (!taken) begin
            @(posedge clk);
            taken = cfg_ready;
            @(negedge clk);
        end
        cfg_valid = 1'b0;
        seed_q    = s;
    endtask

    // Stream from the reset seed, then a restart that must repeat it
    task automatic test_reset_stream();
        repeat (4) send_request(1'b0);
        send_request(1'b1);
        send_request(1'b0);
        drain_words();
    endtask

    // Restarts from extreme and patterned seeds
    task automatic test_seed_extremes();
        write_seed(64'hFFFF_FFFF_FFFF_FFFF);
        send_request(1'b1);
        send_request(1'b0);
        send_request(1'b0);
        drain_words();
        write_seed(64'h8000_0000_0000_0001);
        send_request(1'b1);
        drain_words();
        write_seed(64'hAAAA_AAAA_AAAA_AAAA);
        send_request(1'b1);
        send_request(1'b0);
        drain_words();
        write_seed(64'h5555_5555_5555_5555);
        send_request(1'b1);
        drain_words();
        // seed write alone must not re-seed
        write_seed(64'h0);
        send_request(1'b0);
        send_request(1'b1);
        send_request(1'b1);
        drain_words();
    endtask

    // Long random stream, new seed per phase, sparse restarts
    task automatic test_random_stream();
        logic [63:0] s;
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       s = 64'h0;
                1:       s = 64'hFFFF_FFFF_FFFF_FFFF;
                default: s = {$urandom, $urandom};
            endcase
            write_seed(s);
            send_burst = ($urandom_range(0, 3) == 0);
            rsp_burst  = ($urandom_range(0, 3) == 0);
            send_request(1'b1);
            for (int i = 1; i < PHASE_ITEMS; i++) begin
                send_request($urandom_range(0, 11) == 0);
                if ((p == 3 && i == PHASE_ITEMS / 2) || $urandom_range(0, 199) == 0)
                    drain_words();
            end
            drain_words();
        end
        send_burst = 1'b0;
        rsp_burst  = 1'b0;
    endtask

    initial begin
        seed_q = 64'd0;
        reseed_states(64'd0);
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        test_reset_stream();
        test_seed_extremes();
        test_random_stream();

        drain_words();
        repeat (30) @(negedge clk);
        if (expected_words.size() != 0)
            mismatches = mismatches + 1;
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog
    initial begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
